// ===== hdl/snsq_pkg.sv =====
// ----------------------------------------------------------------------------
// snsq_pkg
// shared types and opcodes for the spi nor command sequencer
// ----------------------------------------------------------------------------
package snsq_pkg;

  localparam int ADDR_W = 24;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 16;
  localparam int STEP_W = 3;

  // request kinds, encoded as on the command port
  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_PROG   = 3'd1,
    OP_SERASE = 3'd2,
    OP_BERASE = 3'd3,
    OP_CERASE = 3'd4,
    OP_RDID   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ACT_SEND = 2'd0,
    ACT_WAIT = 2'd1,
    ACT_RECV = 2'd2
  } act_e;

  typedef enum logic {
    FR_ACCEPT,
    FR_DIVIDE
  } front_state_e;

  // flash opcodes
  localparam logic [BYTE_W-1:0] CMD_WREN    = 8'h06;
  localparam logic [BYTE_W-1:0] CMD_PP      = 8'h02;
  localparam logic [BYTE_W-1:0] CMD_READ    = 8'h03;
  localparam logic [BYTE_W-1:0] CMD_SE      = 8'h20;
  localparam logic [BYTE_W-1:0] CMD_BE      = 8'hD8;
  localparam logic [BYTE_W-1:0] CMD_CE      = 8'h60;
  localparam logic [BYTE_W-1:0] CMD_RDID    = 8'h9F;
  localparam logic [BYTE_W-1:0] SECTOR_MASK = 8'hF0;
  localparam logic [CNT_W-1:0]  RDID_LEN    = 16'd3;

  // step of a program descriptor that carries the data byte
  localparam logic [STEP_W-1:0] STEP_PROG_DATA = 3'd6;

  // work item handed from front to back
  typedef struct packed {
    op_e                op;
    logic [STEP_W-1:0]  first;
    logic               closes;
    logic               last;
    logic [ADDR_W-1:0]  addr;
    logic [BYTE_W-1:0]  data;
    logic [CNT_W-1:0]   count;
  } desc_t;

  // one spi action
  typedef struct packed {
    act_e               action;
    logic [BYTE_W-1:0]  byte_out;
    logic               sel_begin;
    logic               sel_end;
    logic [CNT_W-1:0]   count;
    logic               final_res;
  } res_t;

endpackage

// ===== hdl/snsq_fifo.sv =====
// ----------------------------------------------------------------------------
// snsq_fifo
// small register fifo used between front, back and the result port
// ----------------------------------------------------------------------------
module snsq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] entries_q [DEPTH];
  logic [PW:0]      wr_ptr_q, wr_ptr_d;
  logic [PW:0]      rd_ptr_q, rd_ptr_d;
  logic             do_push, do_pop;

  assign empty_o = (wr_ptr_q == rd_ptr_q);
  assign full_o  = (wr_ptr_q == {~rd_ptr_q[PW], rd_ptr_q[PW-1:0]});
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = entries_q[rd_ptr_q[PW-1:0]];

  assign wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
  assign rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q[PW-1:0]] <= wdata_i;
    end
  end

endmodule

// ===== hdl/snsq_front.sv =====
// ----------------------------------------------------------------------------
// snsq_front
// accepts requests, tracks the program run and builds work descriptors
// ----------------------------------------------------------------------------
module snsq_front
  import snsq_pkg::*;
#(
  parameter int PAGE_BYTES      = 256,
  parameter int READ_COUNT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [2:0]          command_i,
  input  logic [ADDR_W-1:0]   address_i,
  input  logic [BYTE_W-1:0]   data_i,
  input  logic [CNT_W-1:0]    count_i,
  input  logic                last_i,
  output desc_t               desc_o,
  output logic                desc_push_o,
  input  logic                desc_full_i
);

  localparam int OFF_W     = $clog2(PAGE_BYTES);
  localparam int DIV_STEPS = 2;
  localparam int DIV_CNT_W = 2;
  // floor(a / PAGE_BYTES) == (a * RECIP_M) >> RECIP_SH for every 24-bit a
  localparam int RECIP_SH  = ADDR_W + OFF_W;
  localparam int RECIP_W   = ADDR_W + 1;
  localparam int PROD_W    = ADDR_W + RECIP_W;
  localparam longint unsigned RECIP_M =
    ((64'd1 << RECIP_SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);

  front_state_e          state_q, state_d;
  logic [ADDR_W-1:0]     prog_addr_q;
  logic [OFF_W-1:0]      page_off_q;
  logic                  run_open_q;
  logic                  frame_open_q;

  // page offset of a new run start: quotient by reciprocal multiply,
  // then remainder by a constant multiply and subtract
  logic [ADDR_W-1:0]     quo_q;
  logic [OFF_W-1:0]      rem_q;
  logic [DIV_CNT_W-1:0]  div_cnt_q;
  logic [PROD_W-1:0]     recip_prod;
  logic [ADDR_W-1:0]     quo_back;
  logic [ADDR_W-1:0]     rem_full;
  logic                  div_done;

  logic [ADDR_W-1:0]     hold_addr_q;
  logic [BYTE_W-1:0]     hold_data_q;
  logic                  hold_last_q;

  logic                  accept;
  logic                  cmd_known;
  logic                  cmd_prog;
  logic                  opens_run;
  logic [CNT_W-1:0]      cnt_mask;

  logic [ADDR_W-1:0]     cur_addr;
  logic [OFF_W-1:0]      cur_off;
  logic                  cur_frame_open;
  logic [BYTE_W-1:0]     cur_data;
  logic                  cur_last;
  logic [ADDR_W-1:0]     next_addr;
  logic [OFF_W-1:0]      next_off;
  logic                  closes;
  logic                  prog_step;

  assign accept    = push && !full;
  assign cmd_prog  = (command_i == OP_PROG);
  assign cmd_known = (command_i == OP_READ) || (command_i == OP_PROG) ||
                     (command_i == OP_SERASE) || (command_i == OP_BERASE) ||
                     (command_i == OP_CERASE) || (command_i == OP_RDID);
  assign opens_run = cmd_prog && !run_open_q;
  assign div_done  = (div_cnt_q == '0);

  always_comb begin
    for (int i = 0; i < CNT_W; i++) begin
      cnt_mask[i] = (i < READ_COUNT_BITS);
    end
  end

  assign recip_prod = PROD_W'(hold_addr_q) * PROD_W'(RECIP_M);
  assign quo_back   = quo_q * ADDR_W'(PAGE_BYTES);
  assign rem_full   = hold_addr_q - quo_back;

  // program byte math, from the open run or from the run being opened
  always_comb begin
    if (state_q == FR_DIVIDE) begin
      cur_addr       = hold_addr_q;
      cur_off        = rem_q;
      cur_frame_open = 1'b0;
      cur_data       = hold_data_q;
      cur_last       = hold_last_q;
    end else begin
      cur_addr       = prog_addr_q;
      cur_off        = page_off_q;
      cur_frame_open = frame_open_q;
      cur_data       = data_i;
      cur_last       = last_i;
    end
    next_addr = cur_addr + 1'b1;
    // the address wrap is a page boundary too
    if ((cur_off == OFF_W'(PAGE_BYTES - 1)) || (next_addr == '0)) begin
      next_off = '0;
    end else begin
      next_off = cur_off + 1'b1;
    end
    closes = cur_last || (next_off == '0);
  end

  // descriptor
  always_comb begin
    desc_o.op     = (state_q == FR_DIVIDE) ? OP_PROG : op_e'(command_i);
    desc_o.first  = '0;
    desc_o.closes = 1'b0;
    desc_o.last   = 1'b0;
    desc_o.addr   = address_i;
    desc_o.data   = data_i;
    desc_o.count  = count_i & cnt_mask;
    case (desc_o.op)
      OP_SERASE: begin
        desc_o.addr[15:8] = address_i[15:8] & SECTOR_MASK;
      end
      OP_BERASE: begin
        desc_o.addr[15:8] = '0;
      end
      OP_PROG: begin
        desc_o.addr   = cur_addr;
        desc_o.first  = cur_frame_open ? STEP_PROG_DATA : '0;
        desc_o.closes = closes;
        desc_o.last   = cur_last;
        desc_o.data   = cur_data;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_ACCEPT: begin
        if (accept && opens_run) begin
          state_d = FR_DIVIDE;
        end
      end
      FR_DIVIDE: begin
        if (div_done && !desc_full_i) begin
          state_d = FR_ACCEPT;
        end
      end
      default: state_d = FR_ACCEPT;
    endcase
  end

  // outputs
  always_comb begin
    full        = 1'b1;
    desc_push_o = 1'b0;
    prog_step   = 1'b0;
    case (state_q)
      FR_ACCEPT: begin
        full        = desc_full_i;
        desc_push_o = accept && cmd_known && !opens_run;
        prog_step   = accept && cmd_prog && run_open_q;
      end
      FR_DIVIDE: begin
        desc_push_o = div_done && !desc_full_i;
        prog_step   = div_done && !desc_full_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FR_ACCEPT;
      prog_addr_q  <= '0;
      page_off_q   <= '0;
      run_open_q   <= 1'b0;
      frame_open_q <= 1'b0;
      div_cnt_q    <= '0;
      rem_q        <= '0;
    end else begin
      state_q <= state_d;
      if (prog_step) begin
        prog_addr_q  <= next_addr;
        page_off_q   <= next_off;
        frame_open_q <= !closes;
        run_open_q   <= !cur_last;
      end else if (state_q == FR_ACCEPT && accept && cmd_known && !cmd_prog) begin
        // any other defined request drops an open run without closing it
        run_open_q   <= 1'b0;
        frame_open_q <= 1'b0;
      end
      if (state_q == FR_ACCEPT && accept && opens_run) begin
        rem_q     <= '0;
        div_cnt_q <= DIV_CNT_W'(DIV_STEPS);
      end else if (state_q == FR_DIVIDE && !div_done) begin
        if (div_cnt_q == DIV_CNT_W'(1)) begin
          rem_q <= rem_full[OFF_W-1:0];
        end
        div_cnt_q <= div_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FR_ACCEPT && accept && opens_run) begin
      hold_addr_q <= address_i;
      hold_data_q <= data_i;
      hold_last_q <= last_i;
    end else if (state_q == FR_DIVIDE && div_cnt_q == DIV_CNT_W'(DIV_STEPS)) begin
      quo_q <= ADDR_W'(recip_prod >> RECIP_SH);
    end
  end

  a_frame_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_open_q |-> run_open_q)
    else $error("page frame open outside a program run");

  a_off_in_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    page_off_q <= OFF_W'(PAGE_BYTES - 1))
    else $error("page offset beyond page size");

  a_other_drops_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FR_ACCEPT && accept && cmd_known && !cmd_prog)
      |=> (!run_open_q && !frame_open_q))
    else $error("run still open after a non-program request");

endmodule

// ===== hdl/snsq_back.sv =====
// ----------------------------------------------------------------------------
// snsq_back
// walks each descriptor step by step, one spi action per cycle while the result queue has room
// ----------------------------------------------------------------------------
module snsq_back
  import snsq_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  desc_t  desc_i,
  input  logic   desc_empty_i,
  output logic   desc_pop_o,
  output res_t   res_o,
  output logic   res_push_o,
  input  logic   res_full_i
);

  logic [STEP_W-1:0] step_q;
  logic [STEP_W-1:0] eff_step;
  logic              last_act;

  assign eff_step = step_q + desc_i.first;

  always_comb begin
    res_o          = '0;
    res_o.action   = ACT_SEND;
    last_act       = 1'b0;
    case (desc_i.op)
      OP_READ: begin
        case (eff_step)
          3'd0: res_o.action = ACT_WAIT;
          3'd1: begin
            res_o.byte_out  = CMD_READ;
            res_o.sel_begin = 1'b1;
          end
          3'd2: res_o.byte_out = desc_i.addr[23:16];
          3'd3: res_o.byte_out = desc_i.addr[15:8];
          3'd4: res_o.byte_out = desc_i.addr[7:0];
          default: begin
            res_o.action  = ACT_RECV;
            res_o.count   = desc_i.count;
            res_o.sel_end = 1'b1;
            last_act      = 1'b1;
          end
        endcase
      end
      OP_PROG: begin
        case (eff_step)
          3'd0: res_o.action = ACT_WAIT;
          3'd1: begin
            res_o.byte_out  = CMD_WREN;
            res_o.sel_begin = 1'b1;
            res_o.sel_end   = 1'b1;
          end
          3'd2: begin
            res_o.byte_out  = CMD_PP;
            res_o.sel_begin = 1'b1;
          end
          3'd3: res_o.byte_out = desc_i.addr[23:16];
          3'd4: res_o.byte_out = desc_i.addr[15:8];
          3'd5: res_o.byte_out = desc_i.addr[7:0];
          3'd6: begin
            res_o.byte_out = desc_i.data;
            res_o.sel_end  = desc_i.closes;
            last_act       = !desc_i.last;
          end
          default: begin
            // trailing wait after the last byte of a run
            res_o.action = ACT_WAIT;
            last_act     = 1'b1;
          end
        endcase
      end
      OP_SERASE, OP_BERASE: begin
        case (eff_step)
          3'd0: res_o.action = ACT_WAIT;
          3'd1: begin
            res_o.byte_out  = CMD_WREN;
            res_o.sel_begin = 1'b1;
            res_o.sel_end   = 1'b1;
          end
          3'd2: begin
            res_o.byte_out  = (desc_i.op == OP_SERASE) ? CMD_SE : CMD_BE;
            res_o.sel_begin = 1'b1;
          end
          3'd3: res_o.byte_out = desc_i.addr[23:16];
          3'd4: res_o.byte_out = desc_i.addr[15:8];
          3'd5: res_o.sel_end  = 1'b1;
          default: begin
            res_o.action = ACT_WAIT;
            last_act     = 1'b1;
          end
        endcase
      end
      OP_CERASE: begin
        case (eff_step)
          3'd0: res_o.action = ACT_WAIT;
          3'd1: begin
            res_o.byte_out  = CMD_WREN;
            res_o.sel_begin = 1'b1;
            res_o.sel_end   = 1'b1;
          end
          3'd2: begin
            res_o.byte_out  = CMD_CE;
            res_o.sel_begin = 1'b1;
            res_o.sel_end   = 1'b1;
          end
          default: begin
            res_o.action = ACT_WAIT;
            last_act     = 1'b1;
          end
        endcase
      end
      default: begin
        // read id
        case (eff_step)
          3'd0: res_o.action = ACT_WAIT;
          3'd1: begin
            res_o.byte_out  = CMD_RDID;
            res_o.sel_begin = 1'b1;
          end
          default: begin
            res_o.action  = ACT_RECV;
            res_o.count   = RDID_LEN;
            res_o.sel_end = 1'b1;
            last_act      = 1'b1;
          end
        endcase
      end
    endcase
    res_o.final_res = last_act;
  end

  assign res_push_o = !desc_empty_i && !res_full_i;
  assign desc_pop_o = res_push_o && last_act;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (desc_pop_o) begin
      step_q <= '0;
    end else if (res_push_o) begin
      step_q <= step_q + 1'b1;
    end
  end

  a_wait_bare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.action == ACT_WAIT)
      |-> (res_o.byte_out == '0 && !res_o.sel_begin && !res_o.sel_end))
    else $error("wait action carries send fields");

  a_recv_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.action == ACT_RECV) |-> (res_o.sel_end && res_o.final_res))
    else $error("receive action does not end the request");

  a_step_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_pop_o |=> (step_q == '0))
    else $error("step counter not cleared after a descriptor");

endmodule

// ===== hdl/spi_nor_command_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// spi_nor_command_sequencer_core
// turns flash requests into a stream of spi send / wait / receive actions
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            beat
//  request   in         push / full          command, address, data, count, last
//  action    out        empty / pop          action, byte_out, select_begin,
//                                            select_end, receive_count, final_res
//
//  one action beat per cycle leaves on pop; a request gives zero to eight beats
//  a request is taken every cycle while the descriptor queue has room
//  a program byte that opens a run holds full while a reciprocal multiply
//  and a multiply-subtract find the page offset of the start address
//  reset clears the run, the frame and both queues; no clearing pass
//  a stalled result side fills the result queue, then the descriptor queue,
//  then raises full
//
module spi_nor_command_sequencer_core
  import snsq_pkg::*;
#(
  parameter int PAGE_BYTES      = 256,
  parameter int READ_COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request side
  input  logic               push,
  output logic               full,
  input  logic [2:0]         command_i,
  input  logic [ADDR_W-1:0]  address_i,
  input  logic [BYTE_W-1:0]  data_i,
  input  logic [CNT_W-1:0]   count_i,
  input  logic               last_i,
  // action side
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         action_o,
  output logic [BYTE_W-1:0]  byte_out_o,
  output logic               select_begin_o,
  output logic               select_end_o,
  output logic [CNT_W-1:0]   receive_count_o,
  output logic               final_res_o
);

  localparam int DESC_DEPTH = 2;
  localparam int RES_DEPTH  = 2;
  localparam int DESC_W     = $bits(desc_t);
  localparam int RES_W      = $bits(res_t);

  // front to queue
  desc_t              fr_desc;
  logic               fr_desc_push;
  logic               dq_full;

  // queue to back
  logic [DESC_W-1:0]  dq_rdata;
  logic               dq_empty;
  logic               bk_desc_pop;

  // back to result queue
  res_t               bk_res;
  logic               bk_res_push;
  logic               rq_full;
  logic [RES_W-1:0]   rq_rdata;
  res_t               out_res;

  // front: run tracking, page boundaries, descriptor build
  snsq_front #(
    .PAGE_BYTES      (PAGE_BYTES),
    .READ_COUNT_BITS (READ_COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .command_i   (command_i),
    .address_i   (address_i),
    .data_i      (data_i),
    .count_i     (count_i),
    .last_i      (last_i),
    .desc_o      (fr_desc),
    .desc_push_o (fr_desc_push),
    .desc_full_i (dq_full)
  );

  // short queue that decouples the front from the sequencing back end
  snsq_fifo #(
    .WIDTH (DESC_W),
    .DEPTH (DESC_DEPTH)
  ) u_desc_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_desc_push),
    .wdata_i (fr_desc),
    .full_o  (dq_full),
    .pop_i   (bk_desc_pop),
    .rdata_o (dq_rdata),
    .empty_o (dq_empty)
  );

  // back: one action per cycle from the head descriptor unless rq_full
  snsq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_i       (desc_t'(dq_rdata)),
    .desc_empty_i (dq_empty),
    .desc_pop_o   (bk_desc_pop),
    .res_o        (bk_res),
    .res_push_o   (bk_res_push),
    .res_full_i   (rq_full)
  );

  // result queue parts the back end from the consumer
  snsq_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bk_res_push),
    .wdata_i (bk_res),
    .full_o  (rq_full),
    .pop_i   (pop),
    .rdata_o (rq_rdata),
    .empty_o (empty)
  );

  assign out_res         = res_t'(rq_rdata);
  assign action_o        = out_res.action;
  assign byte_out_o      = out_res.byte_out;
  assign select_begin_o  = out_res.sel_begin;
  assign select_end_o    = out_res.sel_end;
  assign receive_count_o = out_res.count;
  assign final_res_o     = out_res.final_res;

endmodule

// ===== dv/tb_spi_nor_command_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// tb_spi_nor_command_sequencer_core
// self-checking bench: flash requests in, predicted spi action beats checked out
// ----------------------------------------------------------------------------
module tb_spi_nor_command_sequencer_core;
  import snsq_pkg::*;

  // block configuration under test
  localparam int PAGE_BYTES      = 256;
  localparam int READ_COUNT_BITS = 16;

  // command port codes that the block ignores
  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

  // traffic shaping
  localparam int IDLE_PCT     = 22;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 340;
  localparam int MAX_REPORTS  = 10;
  // worst case is far below this: ~800 requests, each up to 8 beats, a
  // run-opening stall, random gaps on both sides and one long hold
  localparam int CYCLE_LIMIT  = 400000;

  // clock, reset and block inputs, all known from time zero
  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              push      = 1'b0;
  logic [2:0]        command_i = '0;
  logic [ADDR_W-1:0] address_i = '0;
  logic [BYTE_W-1:0] data_i    = '0;
  logic [CNT_W-1:0]  count_i   = '0;
  logic              last_i    = 1'b0;
  logic              pop       = 1'b0;

  // block outputs
  logic              full;
  logic              empty;
  logic [1:0]        action_o;
  logic [BYTE_W-1:0] byte_out_o;
  logic              select_begin_o;
  logic              select_end_o;
  logic [CNT_W-1:0]  receive_count_o;
  logic              final_res_o;

  // bench control
  bit          calm        = 1'b0;  // no random idling on either side while set
  int unsigned hold_ticket = 0;     // bumped to ask the receiver for a long hold
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  spi_nor_command_sequencer_core #(
    .PAGE_BYTES      (PAGE_BYTES),
    .READ_COUNT_BITS (READ_COUNT_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .command_i       (command_i),
    .address_i       (address_i),
    .data_i          (data_i),
    .count_i         (count_i),
    .last_i          (last_i),
    .empty           (empty),
    .pop             (pop),
    .action_o        (action_o),
    .byte_out_o      (byte_out_o),
    .select_begin_o  (select_begin_o),
    .select_end_o    (select_end_o),
    .receive_count_o (receive_count_o),
    .final_res_o     (final_res_o)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // sequencer prediction
  // --------------------------------------------------------------------------

  // mirror of the block state, all zero out of reset
  logic [ADDR_W-1:0] prog_addr    = '0;
  logic              run_active   = 1'b0;
  logic              frame_active = 1'b0;

  // action beats still owed by the block, oldest first
  res_t expected_actions[$];

  function automatic void emit_action(act_e act, logic [BYTE_W-1:0] b, logic sb,
                                      logic se, logic [CNT_W-1:0] cnt);
    res_t r;
    r.action    = act;
    r.byte_out  = b;
    r.sel_begin = sb;
    r.sel_end   = se;
    r.count     = cnt;
    r.final_res = 1'b0;
    expected_actions.push_back(r);
  endfunction

  // wait, write enable, opcode plus two address bytes and a zero low byte, wait
  function automatic void emit_erase(logic [BYTE_W-1:0] opcode, logic [BYTE_W-1:0] hi,
                                     logic [BYTE_W-1:0] mid);
    emit_action(ACT_WAIT, '0, 1'b0, 1'b0, '0);
    emit_action(ACT_SEND, CMD_WREN, 1'b1, 1'b1, '0);
    emit_action(ACT_SEND, opcode, 1'b1, 1'b0, '0);
    emit_action(ACT_SEND, hi, 1'b0, 1'b0, '0);
    emit_action(ACT_SEND, mid, 1'b0, 1'b0, '0);
    emit_action(ACT_SEND, 8'h00, 1'b0, 1'b1, '0);
    emit_action(ACT_WAIT, '0, 1'b0, 1'b0, '0);
  endfunction

  function automatic void predict_request(logic [2:0] cmd, logic [ADDR_W-1:0] addr,
                                          logic [BYTE_W-1:0] data, logic [CNT_W-1:0] cnt,
                                          logic is_last);
    int   first_idx;
    logic closes;
    first_idx = expected_actions.size();
    // undefined codes leave no trace at all
    if (cmd == CMD_UNUSED_6 || cmd == CMD_UNUSED_7) return;
    // anything but a program byte drops an open run without a closing beat
    if (cmd != OP_PROG) begin
      run_active   = 1'b0;
      frame_active = 1'b0;
    end
    case (cmd)
      OP_READ: begin
        // count port is exactly READ_COUNT_BITS wide, so no masking
        emit_action(ACT_WAIT, '0, 1'b0, 1'b0, '0);
        emit_action(ACT_SEND, CMD_READ, 1'b1, 1'b0, '0);
        emit_action(ACT_SEND, addr[23:16], 1'b0, 1'b0, '0);
        emit_action(ACT_SEND, addr[15:8], 1'b0, 1'b0, '0);
        emit_action(ACT_SEND, addr[7:0], 1'b0, 1'b0, '0);
        emit_action(ACT_RECV, '0, 1'b0, 1'b1, cnt);
      end
      OP_PROG: begin
        if (!run_active) begin
          prog_addr    = addr;
          run_active   = 1'b1;
          frame_active = 1'b0;
        end
        if (!frame_active) begin
          emit_action(ACT_WAIT, '0, 1'b0, 1'b0, '0);
          emit_action(ACT_SEND, CMD_WREN, 1'b1, 1'b1, '0);
          emit_action(ACT_SEND, CMD_PP, 1'b1, 1'b0, '0);
          emit_action(ACT_SEND, prog_addr[23:16], 1'b0, 1'b0, '0);
          emit_action(ACT_SEND, prog_addr[15:8], 1'b0, 1'b0, '0);
          emit_action(ACT_SEND, prog_addr[7:0], 1'b0, 1'b0, '0);
          frame_active = 1'b1;
        end
        // 24-bit wrap to zero lands on a page boundary as well
        prog_addr = prog_addr + 1'b1;
        closes    = is_last || ((prog_addr % PAGE_BYTES) == 0);
        emit_action(ACT_SEND, data, 1'b0, closes, '0);
        if (closes) frame_active = 1'b0;
        if (is_last) begin
          emit_action(ACT_WAIT, '0, 1'b0, 1'b0, '0);
          run_active = 1'b0;
        end
      end
      OP_SERASE: emit_erase(CMD_SE, addr[23:16], addr[15:8] & SECTOR_MASK);
      OP_BERASE: emit_erase(CMD_BE, addr[23:16], 8'h00);
      OP_CERASE: begin
        emit_action(ACT_WAIT, '0, 1'b0, 1'b0, '0);
        emit_action(ACT_SEND, CMD_WREN, 1'b1, 1'b1, '0);
        emit_action(ACT_SEND, CMD_CE, 1'b1, 1'b1, '0);
        emit_action(ACT_WAIT, '0, 1'b0, 1'b0, '0);
      end
      OP_RDID: begin
        emit_action(ACT_WAIT, '0, 1'b0, 1'b0, '0);
        emit_action(ACT_SEND, CMD_RDID, 1'b1, 1'b0, '0);
        emit_action(ACT_RECV, '0, 1'b0, 1'b1, RDID_LEN);
      end
      default: ;
    endcase
    // last beat of this request carries the final mark
    if (expected_actions.size() > first_idx)
      expected_actions[expected_actions.size() - 1].final_res = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  // called at a rising edge; returns at the edge that took the beat, with
  // push still high so a following beat can go out back to back
  task automatic send_request(input logic [2:0] cmd, input logic [ADDR_W-1:0] addr,
                              input logic [BYTE_W-1:0] data, input logic [CNT_W-1:0] cnt,
                              input logic is_last);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    command_i <= cmd;
    address_i <= addr;
    data_i    <= data;
    count_i   <= cnt;
    last_i    <= is_last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_request(cmd, addr, data, cnt, is_last);
  endtask

  // program bytes from one start address; later beats carry junk addresses,
  // which the block must ignore while the run is open
  task automatic send_program_run(input logic [ADDR_W-1:0] start, input int len,
                                  input bit close_run);
    for (int i = 0; i < len; i++)
      send_request(OP_PROG, (i == 0) ? start : ADDR_W'($urandom), BYTE_W'($urandom),
                   CNT_W'($urandom), close_run && (i == len - 1));
  endtask

  // start addresses lean toward the end of a page and the top of the flash
  function automatic logic [ADDR_W-1:0] random_start();
    logic [ADDR_W-1:0] a;
    a = ADDR_W'($urandom);
    if ($urandom_range(0, 1)) a[7:0] = 8'hF0 | 8'($urandom_range(0, 15));
    if ($urandom_range(0, 9) == 0) a[23:8] = 16'hFFFF;
    return a;
  endfunction

  function automatic logic [2:0] random_op();
    op_e kinds[6];
    kinds = '{OP_READ, OP_PROG, OP_SERASE, OP_BERASE, OP_CERASE, OP_RDID};
    return kinds[$urandom_range(0, 5)];
  endfunction

  task automatic send_random_single();
    send_request(random_op(), ADDR_W'($urandom), BYTE_W'($urandom), CNT_W'($urandom),
                 1'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // action side
  // --------------------------------------------------------------------------

  // pop with random stalls; a new hold ticket freezes pop for a long stretch
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  always @(posedge clk_i) begin
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  function automatic void note_mismatch(bit stray, res_t want, res_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      if (stray)
        $display("stray beat: act=%0d byte=%02h sb=%0b se=%0b cnt=%0d fin=%0b",
                 got.action, got.byte_out, got.sel_begin, got.sel_end, got.count,
                 got.final_res);
      else
        $display("beat mismatch: exp act=%0d byte=%02h sb=%0b se=%0b cnt=%0d fin=%0b",
                 want.action, want.byte_out, want.sel_begin, want.sel_end, want.count,
                 want.final_res, " | got act=%0d byte=%02h sb=%0b se=%0b cnt=%0d fin=%0b",
                 got.action, got.byte_out, got.sel_begin, got.sel_end, got.count,
                 got.final_res);
    end
  endfunction

  // every taken action beat against the oldest prediction
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && pop && !empty) begin
      got.action    = act_e'(action_o);
      got.byte_out  = byte_out_o;
      got.sel_begin = select_begin_o;
      got.sel_end   = select_end_o;
      got.count     = receive_count_o;
      got.final_res = final_res_o;
      if (expected_actions.size() == 0) begin
        note_mismatch(1'b1, got, got);
      end else begin
        want = expected_actions.pop_front();
        if (got !== want) note_mismatch(1'b0, want, got);
      end
    end
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // address and count extremes, zero-length read included
  task automatic test_read_requests();
    send_request(OP_READ, 24'h000000, 8'hFF, 16'h0000, 1'b1);
    send_request(OP_READ, 24'hFFFFFF, 8'h00, 16'hFFFF, 1'b0);
    send_request(OP_READ, 24'hA55AC3, 8'h5A, 16'h0001, 1'b1);
  endtask

  // all erase kinds; sector erase keeps only the top nibble of the middle byte
  task automatic test_erase_requests();
    send_request(OP_SERASE, 24'hFFFFFF, 8'hFF, 16'hFFFF, 1'b1);
    send_request(OP_SERASE, 24'h123456, 8'h00, 16'h0000, 1'b0);
    send_request(OP_BERASE, 24'hFFFFFF, 8'hFF, 16'hFFFF, 1'b1);
    send_request(OP_CERASE, 24'h000000, 8'h00, 16'h0000, 1'b0);
  endtask

  task automatic test_read_id();
    send_request(OP_RDID, 24'hFFFFFF, 8'hFF, 16'hFFFF, 1'b1);
  endtask

  task automatic test_program_runs();
    // crosses a page boundary: the frame closes and a new one opens at 0x000100
    send_program_run(24'h0000FE, 3, 1'b1);
    // top of the flash: the address wraps to zero and counts as a boundary
    send_program_run(24'hFFFFFF, 2, 1'b1);
    // one-byte run with extreme data
    send_request(OP_PROG, 24'h800000, 8'h00, 16'hFFFF, 1'b1);
    // run cut off by another request, no closing beat; then a fresh run
    send_request(OP_PROG, 24'h0010F0, 8'hFF, 16'h0000, 1'b0);
    send_request(OP_PROG, 24'hFFFFFF, 8'h81, 16'h0000, 1'b0);
    send_request(OP_RDID, 24'h000000, 8'h00, 16'h0000, 1'b0);
    send_request(OP_PROG, 24'h7FFFFF, 8'h7E, 16'h0000, 1'b1);
  endtask

  // codes six and seven give nothing, also in the middle of an open run
  task automatic test_undefined_commands();
    send_request(OP_PROG, 24'h00AB10, 8'h11, 16'h0000, 1'b0);
    send_request(CMD_UNUSED_6, 24'hFFFFFF, 8'hFF, 16'hFFFF, 1'b1);
    send_request(CMD_UNUSED_7, 24'h000000, 8'h00, 16'h0000, 1'b0);
    send_request(OP_PROG, 24'h000000, 8'h22, 16'h0000, 1'b1);
  endtask

  // long stretch with neither side idling
  task automatic test_back_to_back();
    calm = 1'b1;
    for (int i = 0; i < 8; i++) begin
      send_program_run(random_start(), $urandom_range(1, 12), 1'b1);
      send_random_single();
    end
    calm = 1'b0;
  endtask

  // receiver stops while requests keep coming, so both queues fill and
  // full has to hold the sender off
  task automatic test_backpressure();
    calm        = 1'b1;
    hold_ticket = hold_ticket + 1;
    for (int i = 0; i < 60; i++)
      send_request((i % 2) ? OP_SERASE : OP_READ, ADDR_W'($urandom), BYTE_W'($urandom),
                   CNT_W'($urandom), 1'b0);
    calm = 1'b0;
  endtask

  // mostly well-formed program runs, mixed with single requests, runs left
  // open and the odd undefined code
  task automatic test_random_traffic();
    int sent;
    int pick;
    int len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 20);
        send_program_run(random_start(), len, $urandom_range(0, 99) >= 15);
        sent += len;
      end else if (pick < 95) begin
        send_random_single();
        sent++;
      end else begin
        send_request($urandom_range(0, 1) ? CMD_UNUSED_6 : CMD_UNUSED_7, ADDR_W'($urandom),
                     BYTE_W'($urandom), CNT_W'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_read_requests();
    test_erase_requests();
    test_read_id();
    test_program_runs();
    test_undefined_commands();
    test_back_to_back();
    test_backpressure();
    test_random_traffic();

    // stop offering, let the block drain, then watch for stray beats
    push <= 1'b0;
    while (expected_actions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/snsq_pkg.sv
hdl/snsq_fifo.sv
hdl/snsq_front.sv
hdl/snsq_back.sv
hdl/spi_nor_command_sequencer_core.sv
dv/tb_spi_nor_command_sequencer_core.sv
